// ===== src/fcma_pkg.sv =====
`timescale 1ns / 1ps
package fcma_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 31;
  localparam logic [CfgIdxW-1:0] RegLookX = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLookY = 2'd1;
  localparam logic [CfgIdxW-1:0] RegLookZ = 2'd2;
  localparam logic [CfgIdxW-1:0] RegDist = 2'd3;
  localparam int unsigned DivW = 38;
endpackage

// ===== src/fcma_ram.sv =====
`timescale 1ns / 1ps
module fcma_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/fcma_div.sv =====
`timescale 1ns / 1ps
// Signed by unsigned restoring divider, truncates toward zero, one bit per cycle.
module fcma_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [fcma_pkg::DivW-1:0] num_i,
  input  logic [4:0]                      den_i,
  output logic                            done_o,
  output logic signed [fcma_pkg::DivW-1:0] quo_o
);
  import fcma_pkg::*;
  localparam int unsigned CntW = $clog2(DivW + 1);

  logic [DivW-1:0] mag_q, quo_q;
  logic [5:0]      rem_q;
  logic [4:0]      den_q;
  logic            neg_q, busy_q;
  logic [CntW-1:0] cnt_q;
  logic [5:0]      trial;

  assign trial = {rem_q[4:0], mag_q[DivW-1]};
  assign quo_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DivW-1];
      mag_q <= num_i[DivW-1] ? DivW'(-num_i) : DivW'(num_i);
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[DivW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[DivW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[DivW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== src/follow_camera_moving_average.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | rot_*_i, trans_*_i
// out     | output    | out_valid_o/out_ready_i | aim_*_o, cam_*_o, upward_*_o
// cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
// One transaction at a time; a new item is taken only after the last result is accepted.
// The work per item is set by one shared bit-serial divider (three quotients per axis)
// and by the multiply steps, which are repeated for each axis.
// Reset clears fill counts, slots and sums; ring memories need no clearing.
// The result register holds while out_ready_i is low; no new item enters then.
module follow_camera_moving_average #(
  parameter int unsigned LONG_WINDOW  = 20,
  parameter int unsigned SHORT_WINDOW = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [fcma_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fcma_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  logic signed [15:0] rot_00_i, rot_01_i, rot_02_i,
  input  logic signed [15:0] rot_10_i, rot_11_i, rot_12_i,
  input  logic signed [15:0] rot_20_i, rot_21_i, rot_22_i,
  input  logic signed [31:0] trans_x_i, trans_y_i, trans_z_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output logic signed [31:0] aim_x_o, aim_y_o, aim_z_o,
  output logic signed [31:0] cam_x_o, cam_y_o, cam_z_o,
  output logic signed [15:0] upward_x_o, upward_y_o, upward_z_o
);
  import fcma_pkg::*;
  localparam int unsigned SW = (SHORT_WINDOW > 1) ? $clog2(SHORT_WINDOW) : 1;
  localparam int unsigned LW = $clog2(LONG_WINDOW);
  localparam int unsigned SD = 1 << SW;
  localparam int unsigned SFW = $clog2(SHORT_WINDOW + 1);
  localparam int unsigned LFW = $clog2(LONG_WINDOW + 1);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StMul  = 4'd1;
  localparam logic [3:0] StAcc  = 4'd2;
  localparam logic [3:0] StRd   = 4'd3;
  localparam logic [3:0] StUpd  = 4'd4;
  localparam logic [3:0] StDivA = 4'd5;
  localparam logic [3:0] StDivC = 4'd6;
  localparam logic [3:0] StDivU = 4'd7;
  localparam logic [3:0] StNext = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;

  logic signed [15:0] look_q [3];
  logic [30:0] dist_q;
  logic signed [15:0] rot_q [3][3];
  logic signed [31:0] tr_q [3];
  logic [3:0] st_q;
  logic [1:0] ax_q, j_q;
  logic signed [47:0] ld_q [3];
  logic signed [65:0] acc_q;
  logic signed [65:0] prod_q;
  logic signed [31:0] cam_new_q;
  logic signed [34:0] aim_sum_q [3];
  logic signed [36:0] cam_sum_q [3];
  logic signed [20:0] up_sum_q [3];
  logic [SFW-1:0] sfill_q;
  logic [LFW-1:0] lfill_q;
  logic [SW-1:0] sslot_q;
  logic [LW-1:0] lslot_q;
  logic signed [31:0] res_aim_q [3], res_cam_q [3];
  logic signed [15:0] res_up_q [3];

  // ring memories, address = slot*4 + axis
  logic we;
  logic [31:0] aim_rd, cam_rd;
  logic [15:0] up_rd;
  logic [SW+1:0] saddr;
  logic [LW+1:0] laddr;
  assign saddr = {sslot_q, ax_q};
  assign laddr = {lslot_q, ax_q};
  assign we = (st_q == StUpd);

  fcma_ram #(.Width(32), .Depth(SD * 4)) u_aim_ram (
    .clk_i, .we_i(we), .waddr_i(saddr), .wdata_i(tr_q[ax_q]),
    .raddr_i(saddr), .rdata_o(aim_rd));
  fcma_ram #(.Width(32), .Depth((1 << LW) * 4)) u_cam_ram (
    .clk_i, .we_i(we), .waddr_i(laddr), .wdata_i(cam_new_q),
    .raddr_i(laddr), .rdata_o(cam_rd));
  fcma_ram #(.Width(16), .Depth((1 << LW) * 4)) u_up_ram (
    .clk_i, .we_i(we), .waddr_i(laddr), .wdata_i(rot_q[ax_q][1]),
    .raddr_i(laddr), .rdata_o(up_rd));

  logic div_start, div_done;
  logic signed [DivW-1:0] div_num, div_quo;
  logic [4:0] div_den;
  logic [SFW-1:0] sfill_n;
  logic [LFW-1:0] lfill_n;
  logic signed [34:0] aim_sum_d;
  assign sfill_n = (sfill_q < SFW'(SHORT_WINDOW)) ? sfill_q + 1'b1 : sfill_q;
  assign lfill_n = (lfill_q < LFW'(LONG_WINDOW)) ? lfill_q + 1'b1 : lfill_q;
  assign aim_sum_d = (sfill_q == SFW'(SHORT_WINDOW))
                     ? aim_sum_q[ax_q] - 35'($signed(aim_rd)) + 35'(tr_q[ax_q])
                     : aim_sum_q[ax_q] + 35'(tr_q[ax_q]);

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = 5'(lfill_n);
    unique case (st_q)
      StUpd: begin
        div_start = 1'b1;
        div_num = DivW'(aim_sum_d);
        div_den = 5'(sfill_n);
      end
      StDivA: begin
        div_start = div_done;
        div_num = DivW'(cam_sum_q[ax_q]);
      end
      StDivC: begin
        div_start = div_done;
        div_num = DivW'(up_sum_q[ax_q]);
      end
      default: ;
    endcase
  end

  fcma_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
    .den_i(div_den), .done_o(div_done), .quo_o(div_quo));

  assign in_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);

  logic signed [66:0] trunc;
  logic signed [66:0] pos;
  always_comb begin
    trunc = 67'(acc_q);
    if (acc_q < 0) trunc = trunc + 67'sd268435455;
    trunc = trunc >>> 28;
    pos = trunc + 67'(tr_q[ax_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      look_q[0] <= '0;
      look_q[1] <= '0;
      look_q[2] <= 16'sd16384;
      dist_q <= '0;
      st_q <= StIdle;
      ax_q <= '0;
      j_q <= '0;
      sfill_q <= '0;
      lfill_q <= '0;
      sslot_q <= '0;
      lslot_q <= '0;
      for (int i = 0; i < 3; i++) begin
        aim_sum_q[i] <= '0;
        cam_sum_q[i] <= '0;
        up_sum_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegLookX: look_q[0] <= cfg_data_i[15:0];
          RegLookY: look_q[1] <= cfg_data_i[15:0];
          RegLookZ: look_q[2] <= cfg_data_i[15:0];
          RegDist:  dist_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (st_q)
        StIdle: if (in_valid_i) begin
          st_q <= StMul;
          ax_q <= '0;
          j_q <= '0;
        end
        StMul: begin
          if (j_q == 2'd2) begin
            st_q <= StAcc;
            j_q <= '0;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        StAcc: begin
          j_q <= j_q + 1'b1;
          if (j_q == 2'd3) st_q <= StRd;
        end
        StRd: st_q <= StUpd;
        StUpd: begin
          aim_sum_q[ax_q] <= aim_sum_d;
          if (lfill_q == LFW'(LONG_WINDOW)) begin
            cam_sum_q[ax_q] <= cam_sum_q[ax_q] - 37'($signed(cam_rd))
                               + 37'(cam_new_q);
            up_sum_q[ax_q] <= up_sum_q[ax_q] - 21'($signed(up_rd))
                              + 21'(rot_q[ax_q][1]);
          end else begin
            cam_sum_q[ax_q] <= cam_sum_q[ax_q] + 37'(cam_new_q);
            up_sum_q[ax_q] <= up_sum_q[ax_q] + 21'(rot_q[ax_q][1]);
          end
          st_q <= StDivA;
        end
        StDivA: if (div_done) st_q <= StDivC;
        StDivC: if (div_done) st_q <= StDivU;
        StDivU: if (div_done) st_q <= StNext;
        StNext: begin
          if (ax_q == 2'd2) begin
            st_q <= StOut;
            sfill_q <= sfill_n;
            lfill_q <= lfill_n;
            sslot_q <= (32'(sslot_q) + 1 >= SHORT_WINDOW) ? '0 : sslot_q + 1'b1;
            lslot_q <= (32'(lslot_q) + 1 >= LONG_WINDOW) ? '0 : lslot_q + 1'b1;
          end else begin
            ax_q <= ax_q + 1'b1;
            st_q <= StMul;
          end
        end
        StOut: if (out_ready_i) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && in_valid_i) begin
      rot_q[0][0] <= rot_00_i; rot_q[0][1] <= rot_01_i; rot_q[0][2] <= rot_02_i;
      rot_q[1][0] <= rot_10_i; rot_q[1][1] <= rot_11_i; rot_q[1][2] <= rot_12_i;
      rot_q[2][0] <= rot_20_i; rot_q[2][1] <= rot_21_i; rot_q[2][2] <= rot_22_i;
      tr_q[0] <= trans_x_i; tr_q[1] <= trans_y_i; tr_q[2] <= trans_z_i;
    end
    if (st_q == StMul) begin
      ld_q[j_q] <= look_q[j_q] * $signed({1'b0, dist_q});
    end
    if (st_q == StAcc) begin
      if (j_q == 2'd0) acc_q <= '0;
      if (j_q != 2'd3) prod_q <= rot_q[ax_q][j_q] * ld_q[j_q];
      if (j_q != 2'd0) acc_q <= ((j_q == 2'd1) ? 66'sd0 : acc_q) + prod_q;
    end
    if (st_q == StRd) begin
      if (pos > 67'sh7FFFFFFF) cam_new_q <= 32'sh7FFFFFFF;
      else if (pos < -67'sh80000000) cam_new_q <= 32'sh80000000;
      else cam_new_q <= pos[31:0];
    end
    if (div_done) begin
      unique case (st_q)
        StDivA: res_aim_q[ax_q] <= div_quo[31:0];
        StDivC: res_cam_q[ax_q] <= div_quo[31:0];
        StDivU: res_up_q[ax_q] <= div_quo[15:0];
        default: ;
      endcase
    end
  end

  assign aim_x_o = res_aim_q[0]; assign aim_y_o = res_aim_q[1]; assign aim_z_o = res_aim_q[2];
  assign cam_x_o = res_cam_q[0]; assign cam_y_o = res_cam_q[1]; assign cam_z_o = res_cam_q[2];
  assign upward_x_o = res_up_q[0];
  assign upward_y_o = res_up_q[1];
  assign upward_z_o = res_up_q[2];
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import fcma_pkg::*;

  localparam int LongWin  = 20;
  localparam int ShortWin = 4;

  typedef struct {
    shortint rot [9];
    int      tr  [3];
  } pose_t;

  typedef struct {
    int      aim [3];
    int      cam [3];
    shortint up  [3];
  } view_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] rot_00_i = '0, rot_01_i = '0, rot_02_i = '0;
  logic signed [15:0] rot_10_i = '0, rot_11_i = '0, rot_12_i = '0;
  logic signed [15:0] rot_20_i = '0, rot_21_i = '0, rot_22_i = '0;
  logic signed [31:0] trans_x_i = '0, trans_y_i = '0, trans_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] aim_x_o, aim_y_o, aim_z_o;
  logic signed [31:0] cam_x_o, cam_y_o, cam_z_o;
  logic signed [15:0] upward_x_o, upward_y_o, upward_z_o;

  follow_camera_moving_average dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // camera smoothing state mirrored in the bench
  longint look [3];
  longint follow_dist;
  longint aim_hist [ShortWin][3];
  longint cam_hist [LongWin][3];
  longint up_hist [LongWin][3];
  longint aim_acc [3], cam_acc [3], up_acc [3];
  int short_cnt, long_cnt, short_pos, long_pos;

  view_t pending_views [$];
  int errors = 0;
  bit idle_on = 1'b1;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic view_t smooth_pose(pose_t p);
    view_t  v;
    longint ld [3];
    longint acc;
    longint cam_raw [3];
    for (int k = 0; k < 3; k++) ld[k] = look[k] * follow_dist;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += longint'(p.rot[i*3+j]) * ld[j];
      acc = acc / 64'sd268435456;
      cam_raw[i] = clamp32(acc + longint'(p.tr[i]));
    end
    for (int i = 0; i < 3; i++) begin
      if (short_cnt >= ShortWin) aim_acc[i] -= aim_hist[short_pos][i];
      aim_acc[i] += p.tr[i];
      aim_hist[short_pos][i] = p.tr[i];
    end
    if (short_cnt < ShortWin) short_cnt++;
    short_pos = (short_pos + 1 >= ShortWin) ? 0 : short_pos + 1;
    for (int i = 0; i < 3; i++) begin
      if (long_cnt >= LongWin) begin
        cam_acc[i] -= cam_hist[long_pos][i];
        up_acc[i] -= up_hist[long_pos][i];
      end
      cam_acc[i] += cam_raw[i];
      up_acc[i] += p.rot[i*3+1];
      cam_hist[long_pos][i] = cam_raw[i];
      up_hist[long_pos][i] = p.rot[i*3+1];
    end
    if (long_cnt < LongWin) long_cnt++;
    long_pos = (long_pos + 1 >= LongWin) ? 0 : long_pos + 1;
    for (int i = 0; i < 3; i++) begin
      v.aim[i] = int'(aim_acc[i] / short_cnt);
      v.cam[i] = int'(cam_acc[i] / long_cnt);
      v.up[i] = shortint'(up_acc[i] / long_cnt);
    end
    return v;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
    errors++;
  endtask

  always @(posedge clk_i) begin : check_results
    view_t w;
    if (out_valid_o && out_ready_i) begin
      if (pending_views.size() == 0) begin
        $display("unexpected result transaction at %0t", $time);
        errors++;
      end else begin
        w = pending_views[0];
        pending_views.delete(0);
        if (aim_x_o != w.aim[0]) report_mismatch("aim_x", aim_x_o, w.aim[0]);
        if (aim_y_o != w.aim[1]) report_mismatch("aim_y", aim_y_o, w.aim[1]);
        if (aim_z_o != w.aim[2]) report_mismatch("aim_z", aim_z_o, w.aim[2]);
        if (cam_x_o != w.cam[0]) report_mismatch("cam_x", cam_x_o, w.cam[0]);
        if (cam_y_o != w.cam[1]) report_mismatch("cam_y", cam_y_o, w.cam[1]);
        if (cam_z_o != w.cam[2]) report_mismatch("cam_z", cam_z_o, w.cam[2]);
        if (upward_x_o != w.up[0]) report_mismatch("upward_x", upward_x_o, w.up[0]);
        if (upward_y_o != w.up[1]) report_mismatch("upward_y", upward_y_o, w.up[1]);
        if (upward_z_o != w.up[2]) report_mismatch("upward_z", upward_z_o, w.up[2]);
      end
    end
  end

  // receiver back-pressure
  initial begin
    @(posedge rst_ni);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  task automatic send_pose(pose_t p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {rot_00_i, rot_01_i, rot_02_i} <= {p.rot[0], p.rot[1], p.rot[2]};
    {rot_10_i, rot_11_i, rot_12_i} <= {p.rot[3], p.rot[4], p.rot[5]};
    {rot_20_i, rot_21_i, rot_22_i} <= {p.rot[6], p.rot[7], p.rot[8]};
    {trans_x_i, trans_y_i, trans_z_i} <= {p.tr[0], p.tr[1], p.tr[2]};
    do @(posedge clk_i); while (!in_ready_o);
    pending_views.insert(pending_views.size(), smooth_pose(p));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    wait (pending_views.size() == 0);
    @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      RegLookX: look[0] = longint'(signed'(data[15:0]));
      RegLookY: look[1] = longint'(signed'(data[15:0]));
      RegLookZ: look[2] = longint'(signed'(data[15:0]));
      RegDist:  follow_dist = longint'(data);
      default: ;
    endcase
  endtask

  task automatic set_camera(shortint lx, shortint ly, shortint lz, int unsigned d);
    drain();
    write_reg(RegLookX, {15'd0, lx});
    write_reg(RegLookY, {15'h7fff, ly});
    write_reg(RegLookZ, {15'd0, lz});
    write_reg(RegDist, d[30:0]);
    cfg_we_i <= 1'b0;
  endtask

  function automatic pose_t random_pose(bit wild);
    pose_t p;
    for (int k = 0; k < 9; k++)
      p.rot[k] = wild ? shortint'($urandom) : shortint'($urandom_range(0, 32768) - 16384);
    for (int k = 0; k < 3; k++)
      case ($urandom_range(0, 7))
        0: p.tr[k] = 32'h7fffffff;
        1: p.tr[k] = 32'h80000000;
        2, 3: p.tr[k] = int'($urandom_range(0, 32'h000fffff)) - 32'h00080000;
        default: p.tr[k] = int'($urandom);
      endcase
    return p;
  endfunction

  function automatic pose_t flat_pose(shortint r, int t);
    pose_t p;
    for (int k = 0; k < 9; k++) p.rot[k] = r;
    for (int k = 0; k < 3; k++) p.tr[k] = t;
    return p;
  endfunction

  task automatic test_reset_defaults;
    for (int n = 0; n < 3; n++) send_pose(random_pose(1'b0));
  endtask

  task automatic test_extremes;
    set_camera(16384, 0, 0, 31'h7fffffff);
    send_pose(flat_pose(16384, 32'h7fffffff));
    send_pose(flat_pose(-16384, 32'h80000000));
    send_pose(flat_pose(16384, 0));
    set_camera(-32768, -32768, -32768, 31'h7fffffff);
    send_pose(flat_pose(-32768, 32'h80000000));
    send_pose(flat_pose(-32768, 32'h7fffffff));
    send_pose(flat_pose(32767, 32'h80000000));
    set_camera(32767, 32767, 32767, 31'h7fffffff);
    send_pose(flat_pose(32767, 32'h7fffffff));
    send_pose(flat_pose(-32768, 0));
    set_camera(0, -16384, 0, 0);
    for (int n = 0; n < 6; n++) send_pose(flat_pose(-1, -1));
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_camera(0, 0, 16384, 32'h00050000);
        1: set_camera(-16384, 0, 0, 31'h7fffffff);
        2: set_camera(9459, 9459, 9459, 32'h00640000);
        3: set_camera(0, 0, 0, 31'h7fffffff);
        default: set_camera(shortint'($urandom_range(0, 32768) - 16384),
                            shortint'($urandom), shortint'($urandom_range(0, 32768) - 16384),
                            $urandom_range(0, ph[0] ? 32'h7fffffff : 32'h00ffffff));
      endcase
      if (ph == 7) idle_on = 1'b0;
      for (int n = 0; n < 85; n++) send_pose(random_pose($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    look = '{0, 0, 16384};
    follow_dist = 0;
    aim_acc = '{0, 0, 0};
    cam_acc = '{0, 0, 0};
    up_acc = '{0, 0, 0};
    short_cnt = 0;
    long_cnt = 0;
    short_pos = 0;
    long_pos = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_extremes();
    test_random();
    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("FAIL");
    $finish;
  end
endmodule
